// ----- rtl/kci_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kci_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic CFG_LOOP_ENABLE        = 1'b0;
    localparam logic CFG_START_FROM_CURRENT = 1'b1;

    localparam logic [2:0] LANE_LAST = 3'd4;
    localparam logic [5:0] DIV_STEPS = 6'd33;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        yaw;
        logic [15:0]        pitch;
        logic [23:0]        duration_ms;
        logic [15:0]        elapsed_ms;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [15:0]        cam_yaw;
        logic [15:0]        cam_pitch;
        logic               active;
        logic               finished;
        logic               fault;
    } result_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] yaw;
        logic [15:0] pitch;
    } cam_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [23:0] dur;
    } node_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [31:0] t;
    } path_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_SCAN,
        S_FETCH_A,
        S_FETCH_B,
        S_FETCH_C,
        S_SETUP,
        S_CALC
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_LO,
        MD_HI,
        MD_DIV
    } md_state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kci_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kci_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [32:0] mag,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [32:0] quot,
    output logic        done
);
    import kci_pkg::*;

    md_state_t   state_reg, state_next;
    logic [32:0] mag_reg;
    logic [31:0] num_reg;
    logic [31:0] den_reg;
    logic [64:0] prod_reg;
    logic [31:0] rem_reg;
    logic [32:0] sh_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [64:0] prod_full;
    logic [32:0] rem_shift;
    logic        ge;

    assign prod_full = prod_reg + (65'(mag_reg[32:16] * num_reg) << 16);
    assign rem_shift = {rem_reg, sh_reg[32]};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (go) state_next = MD_LO;
            MD_LO:   state_next = MD_HI;
            MD_HI:   state_next = MD_DIV;
            MD_DIV:  if (cnt_reg == DIV_STEPS - 6'd1) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MD_DIV) && (cnt_reg == DIV_STEPS - 6'd1);
            case (state_reg)
                MD_HI:   cnt_reg <= '0;
                MD_DIV:  cnt_reg <= cnt_reg + 6'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (go)
                begin
                    mag_reg <= mag;
                    num_reg <= num;
                    den_reg <= den;
                end
            end
            MD_LO:
            begin
                prod_reg <= 65'(mag_reg[15:0] * num_reg);
            end
            MD_HI:
            begin
                rem_reg <= prod_full[64:33];
                sh_reg  <= prod_full[32:0];
            end
            MD_DIV:
            begin
                rem_reg <= ge ? 32'(rem_shift - {1'b0, den_reg}) : rem_shift[31:0];
                sh_reg  <= {sh_reg[31:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign quot = sh_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/keyframe_camera_interpolator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keyframe camera interpolator.
// An item is taken on cmd when start is high and busy is low. Clear and
// append items leave busy low. A start item copies the node table into the
// path memory, one node per cycle, behind the start item's own pose when
// start_from_current is set. A tick item gives exactly one result on result,
// marked by done for one cycle. An idle, finished or faulted tick answers in
// the cycle after the item. A running tick scans the path memory for its
// segment at one node per cycle, fetches both end nodes and then runs five
// interpolation lanes in turn through one shared multiply and divide unit.
// The receiver cannot stall: done marks each result for exactly one cycle.
// The configuration port writes loop_enable or start_from_current, chosen
// by cfg_index, one per write.
// Reset clears the node count, the path state and the camera; the node and
// path memories are not cleared.
module keyframe_camera_interpolator_top #(
    parameter int MAX_NODES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kci_pkg::cmd_t    cmd,
    output kci_pkg::result_t result,
    output logic             done,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic             cfg_data
);
    import kci_pkg::*;

    localparam int PD  = MAX_NODES + 1;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int PAW = $clog2(PD);
    localparam int PCW = $clog2(PD + 1);

    node_t node_mem [MAX_NODES];
    path_t path_mem [PD];

    state_t        state_reg, state_next;
    logic [CW-1:0] node_count_reg;
    logic          loop_en_reg;
    logic          sfc_reg;
    logic          running_reg;
    logic          from_cur_reg;
    logic [31:0]   path_time_reg;
    logic [31:0]   end_time_reg;
    logic [31:0]   t1_reg;
    logic [PCW-1:0] path_n_reg;
    cam_t          cam_reg;
    result_t       result_reg;
    logic          done_reg;

    logic [CW-1:0]  rd_i_reg;
    logic           rd_v_reg;
    logic [PCW-1:0] wr_j_reg;
    logic [31:0]    acc_reg;
    logic [PCW-1:0] copy_n_reg;
    logic           copy_cn_reg;

    logic [PCW-1:0] k_reg;
    logic           scan_v_reg;
    logic [PAW-1:0] a_idx_reg;
    path_t          ent_a_reg;
    path_t          ent_b_reg;

    logic [2:0]     lane_reg;
    logic [31:0]    res_reg [4];
    logic           neg_reg;
    logic [31:0]    base_reg;

    node_t          node_rdata;
    path_t          path_rdata;
    logic           accept;
    logic           copy_issue;
    logic           copy_done;
    logic [31:0]    tj;
    logic [31:0]    pt;
    logic           wrap;
    logic [31:0]    pt2;
    logic           tick_go;
    logic           scan_hit;
    logic           pw_en;
    logic [PAW-1:0] pw_addr;
    path_t          pw_data;
    logic [PAW-1:0] pr_addr;
    logic signed [32:0] av;
    logic signed [32:0] bv;
    logic signed [32:0] dv;
    logic [32:0]    mag0;
    logic [32:0]    mag;
    logic           neg;
    logic [31:0]    num;
    logic [31:0]    den;
    logic [32:0]    md_q;
    logic           md_done;
    logic [31:0]    wb;

    assign accept     = start && (state_reg == S_IDLE);
    assign copy_issue = rd_i_reg < node_count_reg;
    assign copy_done  = !copy_issue && !rd_v_reg;
    assign tj         = (wr_j_reg == '0) ? 32'd0 : sat_add(acc_reg, {8'd0, node_rdata.dur});
    assign pt         = sat_add(path_time_reg, {16'd0, cmd.elapsed_ms});
    assign wrap       = pt >= end_time_reg;
    assign pt2        = wrap ? (from_cur_reg ? t1_reg : 32'd0) : pt;
    assign tick_go    = running_reg && !(wrap && !loop_en_reg) && (pt2 < end_time_reg);
    assign scan_hit   = scan_v_reg && (path_time_reg < path_rdata.t);
    assign num        = path_time_reg - ent_a_reg.t;
    assign den        = ent_b_reg.t - ent_a_reg.t;
    assign wb         = neg_reg ? base_reg - md_q[31:0] : base_reg + md_q[31:0];

    always_comb
    begin
        case (lane_reg)
            3'd0:
            begin
                av = 33'($signed(ent_a_reg.x));
                bv = 33'($signed(ent_b_reg.x));
            end
            3'd1:
            begin
                av = 33'($signed(ent_a_reg.y));
                bv = 33'($signed(ent_b_reg.y));
            end
            3'd2:
            begin
                av = 33'($signed(ent_a_reg.z));
                bv = 33'($signed(ent_b_reg.z));
            end
            3'd3:
            begin
                av = 33'($signed(ent_a_reg.yaw));
                bv = 33'($signed(ent_b_reg.yaw));
            end
            default:
            begin
                av = 33'($signed(ent_a_reg.pitch));
                bv = 33'($signed(ent_b_reg.pitch));
            end
        endcase
        dv   = bv - av;
        mag0 = dv[32] ? 33'(-dv) : 33'(dv);
        mag  = mag0;
        neg  = dv[32];
        if ((lane_reg >= 3'd3) && (mag0 > 33'd32768))
        begin
            mag = 33'd65536 - mag0;
            neg = !dv[32];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.op == OP_START) && (node_count_reg != '0))
                    state_next = S_COPY;
                else if (accept && (cmd.op == OP_TICK) && tick_go)
                    state_next = S_SCAN;
            end
            S_COPY:    if (copy_done) state_next = S_IDLE;
            S_SCAN:    if (scan_hit) state_next = S_FETCH_A;
            S_FETCH_A: state_next = S_FETCH_B;
            S_FETCH_B: state_next = S_FETCH_C;
            S_FETCH_C: state_next = S_SETUP;
            S_SETUP:   state_next = S_CALC;
            S_CALC:
            begin
                if (md_done)
                    state_next = (lane_reg == LANE_LAST) ? S_IDLE : S_SETUP;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = state_reg != S_IDLE;
        pw_en   = 1'b0;
        pw_addr = '0;
        pw_data = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                    yaw: cmd.yaw, pitch: cmd.pitch, t: 32'd0};
        pr_addr = a_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                pw_en = accept && (cmd.op == OP_START) && sfc_reg;
            end
            S_COPY:
            begin
                pw_en   = rd_v_reg;
                pw_addr = wr_j_reg[PAW-1:0];
                pw_data = '{x: node_rdata.x, y: node_rdata.y, z: node_rdata.z,
                            yaw: node_rdata.yaw, pitch: node_rdata.pitch, t: tj};
            end
            S_SCAN:
            begin
                pr_addr = (k_reg >= PCW'(PD)) ? PAW'(PD - 1) : k_reg[PAW-1:0];
            end
            S_FETCH_B:
            begin
                pr_addr = a_idx_reg + PAW'(1);
            end
            default:
            begin
                pr_addr = a_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.op == OP_APPEND) && (node_count_reg < CW'(MAX_NODES)))
            node_mem[node_count_reg[NAW-1:0]] <= '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                                                 yaw: cmd.yaw, pitch: cmd.pitch,
                                                 dur: cmd.duration_ms};
        node_rdata <= node_mem[rd_i_reg[NAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
            path_mem[pw_addr] <= pw_data;
        path_rdata <= path_mem[pr_addr];
    end

    kci_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (state_reg == S_SETUP),
        .mag   (mag),
        .num   (num),
        .den   (den),
        .quot  (md_q),
        .done  (md_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            loop_en_reg    <= 1'b0;
            sfc_reg        <= 1'b0;
            running_reg    <= 1'b0;
            from_cur_reg   <= 1'b0;
            path_time_reg  <= '0;
            end_time_reg   <= '0;
            t1_reg         <= '0;
            path_n_reg     <= '0;
            cam_reg        <= '0;
            done_reg       <= 1'b0;
            rd_i_reg       <= '0;
            rd_v_reg       <= 1'b0;
            wr_j_reg       <= '0;
            acc_reg        <= '0;
            copy_n_reg     <= '0;
            copy_cn_reg    <= 1'b0;
            k_reg          <= '0;
            scan_v_reg     <= 1'b0;
            lane_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_LOOP_ENABLE)
                    loop_en_reg <= cfg_data;
                else if (cfg_index == CFG_START_FROM_CURRENT)
                    sfc_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.op)
                            OP_CLEAR:
                            begin
                                node_count_reg <= '0;
                            end
                            OP_APPEND:
                            begin
                                if (node_count_reg < CW'(MAX_NODES))
                                    node_count_reg <= node_count_reg + CW'(1);
                            end
                            OP_START:
                            begin
                                running_reg <= 1'b0;
                                rd_i_reg    <= '0;
                                rd_v_reg    <= 1'b0;
                                wr_j_reg    <= PCW'(sfc_reg);
                                acc_reg     <= '0;
                                copy_n_reg  <= PCW'(node_count_reg) + PCW'(sfc_reg);
                                copy_cn_reg <= sfc_reg;
                                if (sfc_reg && (node_count_reg == '0))
                                    cam_reg <= '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                                                 yaw: cmd.yaw, pitch: cmd.pitch};
                            end
                            default:
                            begin
                                done_reg <= !tick_go;
                                if (running_reg)
                                begin
                                    path_time_reg <= pt2;
                                    if (!tick_go)
                                        running_reg <= 1'b0;
                                end
                                k_reg      <= PCW'(1);
                                scan_v_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                S_COPY:
                begin
                    if (copy_issue)
                        rd_i_reg <= rd_i_reg + CW'(1);
                    rd_v_reg <= copy_issue;
                    if (rd_v_reg)
                    begin
                        acc_reg  <= tj;
                        wr_j_reg <= wr_j_reg + PCW'(1);
                        if (wr_j_reg == PCW'(1))
                            t1_reg <= tj;
                        if (copy_n_reg == PCW'(1))
                            cam_reg <= '{x: node_rdata.x, y: node_rdata.y, z: node_rdata.z,
                                         yaw: node_rdata.yaw, pitch: node_rdata.pitch};
                    end
                    if (copy_done && (copy_n_reg >= PCW'(2)))
                    begin
                        end_time_reg  <= acc_reg;
                        path_n_reg    <= copy_n_reg;
                        from_cur_reg  <= copy_cn_reg;
                        path_time_reg <= '0;
                        running_reg   <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    k_reg      <= k_reg + PCW'(1);
                    scan_v_reg <= 1'b1;
                end
                S_FETCH_C:
                begin
                    lane_reg <= '0;
                end
                S_CALC:
                begin
                    if (md_done)
                    begin
                        lane_reg <= lane_reg + 3'd1;
                        if (lane_reg == LANE_LAST)
                        begin
                            done_reg <= 1'b1;
                            cam_reg  <= '{x: res_reg[0], y: res_reg[1], z: res_reg[2],
                                          yaw: res_reg[3][15:0], pitch: wb[15:0]};
                        end
                    end
                end
                default:
                begin
                    lane_reg <= lane_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.op == OP_TICK))
                begin
                    result_reg <= '{cam_x: cam_reg.x, cam_y: cam_reg.y, cam_z: cam_reg.z,
                                    cam_yaw: cam_reg.yaw, cam_pitch: cam_reg.pitch,
                                    active: 1'b0,
                                    finished: running_reg && wrap && !loop_en_reg,
                                    fault: tick_go ? 1'b0 :
                                           (running_reg && !(wrap && !loop_en_reg))};
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                    a_idx_reg <= PAW'(k_reg - PCW'(2));
            end
            S_FETCH_B:
            begin
                ent_a_reg <= path_rdata;
            end
            S_FETCH_C:
            begin
                ent_b_reg <= path_rdata;
            end
            S_SETUP:
            begin
                neg_reg  <= neg;
                base_reg <= av[31:0];
            end
            S_CALC:
            begin
                if (md_done)
                begin
                    if (lane_reg != LANE_LAST)
                        res_reg[lane_reg[1:0]] <= wb;
                    else
                        result_reg <= '{cam_x: res_reg[0], cam_y: res_reg[1],
                                        cam_z: res_reg[2], cam_yaw: res_reg[3][15:0],
                                        cam_pitch: wb[15:0], active: 1'b1,
                                        finished: 1'b0, fault: 1'b0};
                end
            end
            default:
            begin
                a_idx_reg <= a_idx_reg;
            end
        endcase
    end

    assign result = result_reg;
    assign done   = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (path_n_reg >= PCW'(2)))
        else $error("running path with fewer than two nodes");

    assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= CW'(MAX_NODES))
        else $error("node count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg <= path_n_reg))
        else $error("segment scan ran past the path end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> running_reg)
        else $error("interpolation without a running path");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.active && (result_reg.finished || result_reg.fault)))
        else $error("active result also flagged finished or fault");

endmodule

`default_nettype wire

// ----- bench/keyframe_camera_interpolator_top_tb.sv -----
`timescale 1ns / 1ps

module keyframe_camera_interpolator_top_tb;
    import kci_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 400;
    localparam int ITEM_TARGET = 1100;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    result_t result;
    logic    done;
    logic    cfg_wr_en;
    logic    cfg_index;
    logic    cfg_data;

    keyframe_camera_interpolator_top #(.MAX_NODES(TABLE_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result(result),
        .done(done),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted state of the block.
    logic        loop_on;
    logic        from_camera;
    node_t       key_table [TABLE_DEPTH];
    int          key_count;
    path_t       track [TABLE_DEPTH + 1];
    int          track_len;
    logic        track_from_camera;
    logic [31:0] track_time;
    logic [31:0] track_end;
    logic        moving;
    cam_t        camera;

    result_t     camera_queue [$];
    int          mismatches;
    int          items_sent;
    int          ticks_sent;
    int          results_seen;
    logic        idling_on;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] time_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] blend(input longint a, input longint d,
                                          input logic [31:0] num, input logic [31:0] den);
        logic [95:0] mag;
        logic [95:0] q;
        longint      r;
        mag = (d < 0) ? 96'(-d) : 96'(d);
        q = (mag * 96'(num)) / 96'(den);
        r = (d < 0) ? a - longint'(q) : a + longint'(q);
        return r[31:0];
    endfunction

    function automatic logic [15:0] blend_angle(input logic [15:0] av, input logic [15:0] bv,
                                                input logic [31:0] num, input logic [31:0] den);
        longint      a;
        longint      d;
        longint      ad;
        logic [31:0] r;
        a = longint'($signed(av));
        d = longint'($signed(bv)) - a;
        ad = (d < 0) ? -d : d;
        if (ad > 32768)
        begin
            d = (d >= 0) ? -(65536 - ad) : (65536 - ad);
        end
        r = blend(a, d, num, den);
        return r[15:0];
    endfunction

    function automatic result_t camera_result(input logic act, input logic fin, input logic flt);
        result_t r;
        r.cam_x = camera.x;
        r.cam_y = camera.y;
        r.cam_z = camera.z;
        r.cam_yaw = camera.yaw;
        r.cam_pitch = camera.pitch;
        r.active = act;
        r.finished = fin;
        r.fault = flt;
        return r;
    endfunction

    task automatic advance_camera(input cmd_t c);
        int          seg;
        logic [31:0] num;
        logic [31:0] den;
        path_t       pa;
        path_t       pb;
        seg = -1;
        if (!moving)
        begin
            camera_queue.push_back(camera_result(1'b0, 1'b0, 1'b0));
            return;
        end
        track_time = time_add(track_time, {16'd0, c.elapsed_ms});
        if (track_time >= track_end)
        begin
            if (loop_on)
            begin
                track_time = track_from_camera ? track[1].t : 32'd0;
            end
            else
            begin
                moving = 1'b0;
                camera_queue.push_back(camera_result(1'b0, 1'b1, 1'b0));
                return;
            end
        end
        for (int i = 0; i + 1 < track_len; i++)
        begin
            if (seg < 0 && track_time < track[i + 1].t)
            begin
                seg = i;
            end
        end
        if (seg < 0)
        begin
            moving = 1'b0;
            camera_queue.push_back(camera_result(1'b0, 1'b0, 1'b1));
            return;
        end
        pa = track[seg];
        pb = track[seg + 1];
        num = track_time - pa.t;
        den = pb.t - pa.t;
        camera.x = blend(longint'($signed(pa.x)), longint'($signed(pb.x)) - longint'($signed(pa.x)),
                         num, den);
        camera.y = blend(longint'($signed(pa.y)), longint'($signed(pb.y)) - longint'($signed(pa.y)),
                         num, den);
        camera.z = blend(longint'($signed(pa.z)), longint'($signed(pb.z)) - longint'($signed(pa.z)),
                         num, den);
        camera.yaw = blend_angle(pa.yaw, pb.yaw, num, den);
        camera.pitch = blend_angle(pa.pitch, pb.pitch, num, den);
        camera_queue.push_back(camera_result(1'b1, 1'b0, 1'b0));
    endtask

    task automatic begin_path(input cmd_t c);
        int cn;
        int n;
        cn = from_camera ? 1 : 0;
        n = key_count + cn;
        moving = 1'b0;
        if (n == 0)
        begin
            return;
        end
        if (cn == 1)
        begin
            track[0].x = c.pos_x;
            track[0].y = c.pos_y;
            track[0].z = c.pos_z;
            track[0].yaw = c.yaw;
            track[0].pitch = c.pitch;
        end
        for (int i = 0; i < key_count; i++)
        begin
            track[cn + i].x = key_table[i].x;
            track[cn + i].y = key_table[i].y;
            track[cn + i].z = key_table[i].z;
            track[cn + i].yaw = key_table[i].yaw;
            track[cn + i].pitch = key_table[i].pitch;
            track[cn + i].t = {8'd0, key_table[i].dur};
        end
        if (n == 1)
        begin
            camera.x = track[0].x;
            camera.y = track[0].y;
            camera.z = track[0].z;
            camera.yaw = track[0].yaw;
            camera.pitch = track[0].pitch;
            return;
        end
        track[0].t = 32'd0;
        for (int i = 1; i < n; i++)
        begin
            track[i].t = time_add(track[i].t, track[i - 1].t);
        end
        track_len = n;
        track_end = track[n - 1].t;
        track_from_camera = (cn == 1);
        track_time = 32'd0;
        moving = 1'b1;
    endtask

    task automatic predict_item(input cmd_t c);
        case (c.op)
            OP_CLEAR:
            begin
                key_count = 0;
            end
            OP_APPEND:
            begin
                if (key_count < TABLE_DEPTH)
                begin
                    key_table[key_count] = '{c.pos_x, c.pos_y, c.pos_z, c.yaw, c.pitch,
                                             c.duration_ms};
                    key_count++;
                end
            end
            OP_START:
            begin
                begin_path(c);
            end
            default:
            begin
                ticks_sent++;
                advance_camera(c);
            end
        endcase
    endtask

    task automatic send_item(input cmd_t c);
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        items_sent++;
        predict_item(c);
    endtask

    task automatic maybe_idle();
        int n;
        if (idling_on && (items_sent < ITEM_TARGET - 150) && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (camera_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_LOOP_ENABLE)
        begin
            loop_on = val;
        end
        else
        begin
            from_camera = val;
        end
    endtask

    task automatic set_mode(input logic lp, input logic fc);
        drain();
        write_reg(CFG_LOOP_ENABLE, lp);
        write_reg(CFG_START_FROM_CURRENT, fc);
    endtask

    function automatic cmd_t random_cmd(input logic [1:0] op);
        cmd_t c;
        c.op = op;
        c.pos_x = $urandom;
        c.pos_y = $urandom;
        c.pos_z = $urandom;
        c.yaw = 16'($urandom);
        c.pitch = 16'($urandom);
        c.duration_ms = 24'($urandom);
        c.elapsed_ms = 16'($urandom);
        return c;
    endfunction

    function automatic cmd_t node_cmd(input logic [31:0] x, input logic [15:0] ang,
                                      input logic [23:0] dur);
        cmd_t c;
        c = random_cmd(OP_APPEND);
        c.pos_x = x;
        c.pos_y = ~x;
        c.pos_z = x ^ 32'h5A5A_A5A5;
        c.yaw = ang;
        c.pitch = ~ang;
        c.duration_ms = dur;
        return c;
    endfunction

    function automatic cmd_t tick_cmd(input logic [15:0] ms);
        cmd_t c;
        c = random_cmd(OP_TICK);
        c.elapsed_ms = ms;
        return c;
    endfunction

    task automatic test_directed();
        send_item(tick_cmd(16'd5));
        send_item(random_cmd(OP_START));
        send_item(node_cmd(32'h7FFF_FFFF, 16'hFFFF, 24'd10));
        send_item(random_cmd(OP_START));
        send_item(tick_cmd(16'd3));
        send_item(random_cmd(OP_CLEAR));
        send_item(node_cmd(32'h7FFF_FFFF, 16'h0000, 24'd0));
        send_item(node_cmd(32'h8000_0000, 16'h8001, 24'd1000));
        send_item(node_cmd(32'h0000_0000, 16'h7FFF, 24'd0));
        send_item(node_cmd(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF));
        send_item(random_cmd(OP_START));
        send_item(tick_cmd(16'd0));
        send_item(tick_cmd(16'd333));
        send_item(tick_cmd(16'd700));
        send_item(tick_cmd(16'hFFFF));
        for (int i = 0; i < 4; i++)
        begin
            send_item(tick_cmd(16'hFFFF));
        end
        drain();
        repeat (260) send_item(tick_cmd(16'hFFFF));
        send_item(tick_cmd(16'd1));
        set_mode(1'b1, 1'b1);
        send_item(random_cmd(OP_CLEAR));
        send_item(node_cmd(32'h0001_0000, 16'h4000, 24'd100));
        send_item(random_cmd(OP_START));
        send_item(tick_cmd(16'd50));
        send_item(tick_cmd(16'd150));
        send_item(tick_cmd(16'd10));
        set_mode(1'b1, 1'b0);
        send_item(random_cmd(OP_CLEAR));
        send_item(node_cmd(32'h0002_0000, 16'h0100, 24'd0));
        send_item(node_cmd(32'h0003_0000, 16'hFF00, 24'd0));
        send_item(random_cmd(OP_START));
        send_item(tick_cmd(16'd7));
    endtask

    task automatic test_table_full();
        set_mode(1'b0, 1'b0);
        send_item(random_cmd(OP_CLEAR));
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            send_item(node_cmd($urandom, 16'($urandom), 24'($urandom_range(1, 40))));
        end
        send_item(random_cmd(OP_START));
        for (int i = 0; i < 6; i++)
        begin
            send_item(tick_cmd(16'($urandom_range(100, 900))));
        end
    endtask

    task automatic run_path();
        int   nodes;
        int   ticks;
        cmd_t c;
        nodes = ($urandom_range(0, 15) == 0) ? $urandom_range(7, TABLE_DEPTH)
                                              : $urandom_range(0, 6);
        send_item(random_cmd(OP_CLEAR));
        maybe_idle();
        for (int i = 0; i < nodes; i++)
        begin
            c = random_cmd(OP_APPEND);
            case ($urandom_range(0, 19))
                0: c.duration_ms = 24'd0;
                1: c.duration_ms = 24'($urandom);
                default: c.duration_ms = 24'($urandom_range(1, 3000));
            endcase
            send_item(c);
            maybe_idle();
        end
        send_item(random_cmd(OP_START));
        maybe_idle();
        ticks = $urandom_range(2, 12);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(random_cmd(2'($urandom_range(0, 3))));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: send_item(tick_cmd(16'($urandom)));
                    1: send_item(tick_cmd(16'd0));
                    default: send_item(tick_cmd(16'($urandom_range(0, 1500))));
                endcase
            end
            maybe_idle();
        end
    endtask

    task automatic test_random();
        int phase;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            set_mode(phase[0], phase[1]);
            idling_on = (items_sent < ITEM_TARGET - 150);
            for (int k = 0; k < 8 && items_sent < ITEM_TARGET; k++)
            begin
                run_path();
            end
            phase++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (camera_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result %h", result);
                end
            end
            else
            begin
                want = camera_queue.pop_front();
                if (want.cam_x !== result.cam_x || want.cam_y !== result.cam_y ||
                    want.cam_z !== result.cam_z || want.cam_yaw !== result.cam_yaw ||
                    want.cam_pitch !== result.cam_pitch || want.active !== result.active ||
                    want.finished !== result.finished || want.fault !== result.fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected %h, got %h", want, result);
                    end
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("Timed out with %0d results outstanding.", camera_queue.size());
        $display("** keyframe_camera_interpolator_top: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        loop_on = 1'b0;
        from_camera = 1'b0;
        key_count = 0;
        track_len = 0;
        track_from_camera = 1'b0;
        track_time = '0;
        track_end = '0;
        moving = 1'b0;
        camera = '0;
        mismatches = 0;
        items_sent = 0;
        ticks_sent = 0;
        results_seen = 0;
        idling_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random();
        drain();
        if (camera_queue.size() != 0)
        begin
            mismatches++;
        end
        $display("Sent %0d items with %0d ticks and checked %0d results.",
                 items_sent, ticks_sent, results_seen);
        $display("Covered idle, single-node, looping, camera-first, full-table and fault paths.");
        if (mismatches == 0)
        begin
            $display("** keyframe_camera_interpolator_top: PASSED **");
        end
        else
        begin
            $display("** keyframe_camera_interpolator_top: FAILED **");
        end
        $finish;
    end

endmodule
